@@ rtl/qte_pkg.sv @@
// Package for the quaternion to Euler angle converter.
// It holds the CORDIC step count, fixed-point constants and the arctangent table.
// It depends on nothing. The core imports it.
package qte_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;

  localparam logic signed [32:0] HALF_PI_Q29 = 33'sd843314857;
  localparam logic signed [35:0] ONE_Q28     = 36'sd268435456;
  localparam logic signed [33:0] SAT_Q28     = 34'sd268435456;
  localparam logic signed [33:0] PITCH_LIM   = 34'sd12868;
  localparam logic signed [33:0] ANGLE_LIM   = 34'sd25736;
  localparam logic [56:0]        ONE_Q56     = 57'h100000000000000;

  // Arctangent of 2^-i in Q29 radians.
  function automatic logic signed [32:0] atan_tab(input logic [4:0] i);
    logic signed [32:0] r;
    case (i)
      5'd0:  r = 33'sd421657428;
      5'd1:  r = 33'sd248918915;
      5'd2:  r = 33'sd131521918;
      5'd3:  r = 33'sd66762579;
      5'd4:  r = 33'sd33510843;
      5'd5:  r = 33'sd16771758;
      5'd6:  r = 33'sd8387925;
      5'd7:  r = 33'sd4194219;
      5'd8:  r = 33'sd2097141;
      5'd9:  r = 33'sd1048575;
      5'd10: r = 33'sd524288;
      5'd11: r = 33'sd262144;
      5'd12: r = 33'sd131072;
      5'd13: r = 33'sd65536;
      5'd14: r = 33'sd32768;
      5'd15: r = 33'sd16384;
      5'd16: r = 33'sd8192;
      5'd17: r = 33'sd4096;
      5'd18: r = 33'sd2048;
      5'd19: r = 33'sd1024;
      5'd20: r = 33'sd512;
      5'd21: r = 33'sd256;
      5'd22: r = 33'sd128;
      5'd23: r = 33'sd64;
      default: r = 33'sd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/quaternion_to_euler_core.sv @@
// Quaternion to Euler angle converter, top level.
// It depends on qte_pkg for constants and the arctangent table.
// It holds the sequencer, digit-serial multiplier, square root and shared CORDIC.

// One item is one Q2.14 quaternion (w, x, y, z). The block returns roll and yaw in Q3.13
// radians and pitch in Q2.13 radians, with a flag that marks a held roll. The block works
// on one item at a time; the next item can be accepted in the cycle after the result is
// placed in the output register. The multiplier retires four bits per cycle. It forms the
// nine quaternion products, the pitch argument is then saturated, and the multiplier forms
// its square. The integer square root follows. The shared CORDIC then runs pitch, roll and
// yaw in turn, each through a prepare state, CORDIC_STEPS iterations unless its vector is
// zero, and a finish state; a last state moves the result to the output register. When
// roll is held, its CORDIC pass is skipped and the item finishes sooner. Input stall is
// high from acceptance until the result is placed in the output register. A finished
// result may wait there under output stall while the next item is accepted. The
// pole_limit register sits at address 0.
module quaternion_to_euler_core import qte_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] yaw_angle,
  output logic               roll_held,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PLOAD  = 4'd1;
  localparam logic [3:0] ST_PRUN   = 4'd2;
  localparam logic [3:0] ST_SPREP  = 4'd3;
  localparam logic [3:0] ST_SLOAD  = 4'd4;
  localparam logic [3:0] ST_SQRT   = 4'd5;
  localparam logic [3:0] ST_CPREP  = 4'd6;
  localparam logic [3:0] ST_CITER  = 4'd7;
  localparam logic [3:0] ST_CFIN   = 4'd8;
  localparam logic [3:0] ST_OUT    = 4'd9;

  localparam logic [1:0] SEL_PITCH = 2'd0;
  localparam logic [1:0] SEL_ROLL  = 2'd1;
  localparam logic [1:0] SEL_YAW   = 2'd2;

  localparam logic [3:0] LAST_PROD = 4'd8;
  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

  logic [3:0]         state;
  logic [13:0]        pole_limit;
  logic signed [15:0] qw, qx, qy, qz;

  // Digit-serial multiplier.
  logic [3:0]         pidx;
  logic [2:0]         dig;
  logic               sq_mode;
  logic signed [29:0] mul_a;
  logic [31:0]        mul_b;
  logic signed [59:0] mul_p;
  logic signed [32:0] sum_a, sum_r, sum_d, sum_y, sum_e;
  logic signed [29:0] s_val;

  // Integer square root.
  logic [56:0]        sq_v, sq_res, sq_bit;

  // CORDIC.
  logic signed [35:0] cx, cy;
  logic signed [32:0] cacc;
  logic [4:0]         cnt;
  logic [1:0]         csel;
  logic               czero;

  logic signed [14:0] pitch_r;
  logic signed [15:0] roll_r, yaw_r, last_roll;
  logic               held_r;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {18'd0, pole_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pole_limit <= 14'd12458;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      pole_limit <= pwdata[13:0];
    end
  end

  assign in_stall = (state != ST_IDLE);

  // Operands of each quaternion product.
  logic signed [15:0] op_a, op_b;
  always_comb begin
    case (pidx)
      4'd0:    begin op_a = qw; op_b = qy; end
      4'd1:    begin op_a = qx; op_b = qz; end
      4'd2:    begin op_a = qy; op_b = qz; end
      4'd3:    begin op_a = qw; op_b = qx; end
      4'd4:    begin op_a = qx; op_b = qx; end
      4'd5:    begin op_a = qy; op_b = qy; end
      4'd6:    begin op_a = qx; op_b = qy; end
      4'd7:    begin op_a = qw; op_b = qz; end
      default: begin op_a = qz; op_b = qz; end
    endcase
  end

  // One digit of the multiplier a cycle. The top digit is signed.
  logic               mul_last;
  logic signed [4:0]  mul_d;
  logic signed [34:0] partial;
  logic signed [59:0] pp_ext, p_sum;
  logic signed [32:0] prod;
  always_comb begin
    mul_last = (dig == (sq_mode ? 3'd7 : 3'd3));
    mul_d    = mul_last ? {mul_b[3], mul_b[3:0]} : {1'b0, mul_b[3:0]};
    partial  = mul_a * mul_d;
    pp_ext   = {{25{partial[34]}}, partial};
    p_sum    = mul_p + (pp_ext <<< {dig, 2'b00});
    prod     = p_sum[32:0];
  end

  // Pitch argument 2(wy - xz), saturated to one.
  logic signed [33:0] s2;
  logic signed [29:0] s_clamp, s_abs;
  always_comb begin
    s2 = {sum_a, 1'b0};
    if (s2 > SAT_Q28) begin
      s_clamp = SAT_Q28[29:0];
    end else if (s2 < -SAT_Q28) begin
      s_clamp = 30'(-SAT_Q28);
    end else begin
      s_clamp = s2[29:0];
    end
    s_abs = s_val[29] ? -s_val : s_val;
  end

  // One step of the square root.
  logic [56:0] sq_try;
  assign sq_try = sq_res + sq_bit;

  // CORDIC operands for the angle being worked on.
  logic signed [35:0] op_y, op_x;
  always_comb begin
    case (csel)
      SEL_PITCH: begin
        op_y = {{6{s_val[29]}}, s_val};
        op_x = {7'd0, sq_res[28:0]};
      end
      SEL_ROLL: begin
        op_y = {{2{sum_r[32]}}, sum_r, 1'b0};
        op_x = ONE_Q28 - {{2{sum_d[32]}}, sum_d, 1'b0};
      end
      default: begin
        op_y = {{2{sum_y[32]}}, sum_y, 1'b0};
        op_x = ONE_Q28 - {{2{sum_e[32]}}, sum_e, 1'b0};
      end
    endcase
  end

  logic signed [35:0] xs, ys;
  assign xs = cx >>> cnt;
  assign ys = cy >>> cnt;

  // Rounded Q3.13 angle, clamped to the range of the angle.
  logic signed [33:0] rnd, rsh, lim, clamped;
  logic signed [15:0] ang;
  logic [14:0]        apitch;
  always_comb begin
    rnd = {cacc[32], cacc} + 34'sd32768;
    rsh = rnd >>> 16;
    lim = (csel == SEL_PITCH) ? PITCH_LIM : ANGLE_LIM;
    if (rsh > lim) begin
      clamped = lim;
    end else if (rsh < -lim) begin
      clamped = -lim;
    end else begin
      clamped = rsh;
    end
    ang    = czero ? 16'sd0 : clamped[15:0];
    apitch = ang[15] ? 15'(-ang) : ang[14:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      last_roll <= 16'sd0;
    end else begin
      // A result taken while the next one is being loaded is replaced in ST_OUT.
      if (out_valid && !out_stall && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            qw      <= quat_w;
            qx      <= quat_x;
            qy      <= quat_y;
            qz      <= quat_z;
            sum_a   <= '0;
            sum_r   <= '0;
            sum_d   <= '0;
            sum_y   <= '0;
            sum_e   <= '0;
            pidx    <= 4'd0;
            sq_mode <= 1'b0;
            state   <= ST_PLOAD;
          end
        end
        ST_PLOAD: begin
          mul_a <= {{14{op_a[15]}}, op_a};
          mul_b <= {{16{op_b[15]}}, op_b};
          mul_p <= '0;
          dig   <= 3'd0;
          state <= ST_PRUN;
        end
        ST_PRUN: begin
          mul_p <= p_sum;
          mul_b <= {4'd0, mul_b[31:4]};
          dig   <= dig + 3'd1;
          if (mul_last) begin
            if (sq_mode) begin
              sq_v   <= ONE_Q56 - p_sum[56:0];
              sq_res <= '0;
              sq_bit <= ONE_Q56;
              state  <= ST_SQRT;
            end else begin
              case (pidx)
                4'd0:    sum_a <= sum_a + prod;
                4'd1:    sum_a <= sum_a - prod;
                4'd2:    sum_r <= sum_r + prod;
                4'd3:    sum_r <= sum_r + prod;
                4'd4:    sum_d <= sum_d + prod;
                4'd5: begin
                  sum_d <= sum_d + prod;
                  sum_e <= sum_e + prod;
                end
                4'd6:    sum_y <= sum_y + prod;
                4'd7:    sum_y <= sum_y + prod;
                default: sum_e <= sum_e + prod;
              endcase
              pidx  <= pidx + 4'd1;
              state <= (pidx == LAST_PROD) ? ST_SPREP : ST_PLOAD;
            end
          end
        end
        ST_SPREP: begin
          s_val <= s_clamp;
          state <= ST_SLOAD;
        end
        ST_SLOAD: begin
          // Square the magnitude of the pitch argument, eight digits.
          mul_a   <= s_abs;
          mul_b   <= {2'd0, s_abs};
          mul_p   <= '0;
          dig     <= 3'd0;
          sq_mode <= 1'b1;
          state   <= ST_PRUN;
        end
        ST_SQRT: begin
          if (sq_bit == '0) begin
            csel  <= SEL_PITCH;
            state <= ST_CPREP;
          end else begin
            if (sq_v >= sq_try) begin
              sq_v   <= sq_v - sq_try;
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        ST_CPREP: begin
          cnt   <= 5'd0;
          czero <= (op_x == '0) && (op_y == '0);
          if (op_x == '0 && op_y == '0) begin
            state <= ST_CFIN;
          end else begin
            state <= ST_CITER;
            if (op_x[35]) begin
              // Rotate a left-half vector by a quarter turn first.
              if (!op_y[35]) begin
                cx   <= op_y;
                cy   <= -op_x;
                cacc <= HALF_PI_Q29;
              end else begin
                cx   <= -op_y;
                cy   <= op_x;
                cacc <= -HALF_PI_Q29;
              end
            end else begin
              cx   <= op_x;
              cy   <= op_y;
              cacc <= '0;
            end
          end
        end
        ST_CITER: begin
          if (!cy[35]) begin
            cx   <= cx + ys;
            cy   <= cy - xs;
            cacc <= cacc + atan_tab(cnt);
          end else begin
            cx   <= cx - ys;
            cy   <= cy + xs;
            cacc <= cacc - atan_tab(cnt);
          end
          cnt <= cnt + 5'd1;
          if (cnt == LAST_STEP) begin
            state <= ST_CFIN;
          end
        end
        ST_CFIN: begin
          case (csel)
            SEL_PITCH: begin
              pitch_r <= ang[14:0];
              if (apitch < {1'b0, pole_limit}) begin
                held_r <= 1'b0;
                csel   <= SEL_ROLL;
              end else begin
                held_r <= 1'b1;
                roll_r <= last_roll;
                csel   <= SEL_YAW;
              end
              state <= ST_CPREP;
            end
            SEL_ROLL: begin
              roll_r <= ang;
              csel   <= SEL_YAW;
              state  <= ST_CPREP;
            end
            default: begin
              yaw_r <= ang;
              state <= ST_OUT;
            end
          endcase
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            roll_angle  <= roll_r;
            pitch_angle <= pitch_r;
            yaw_angle   <= yaw_r;
            roll_held   <= held_r;
            last_roll   <= roll_r;
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
